### design/klht_pkg.sv
// Shared types and constants for the key-to-level hash table.
// No dependencies; klht_front, klht_back and the top level import this package.
package klht_pkg;

  localparam int KEY_W = 32;
  localparam int LVL_W = 12;
  localparam int CAP_W = 13;

  localparam logic [KEY_W-1:0] HASH_MULT   = 32'h9E37_79B1;
  localparam logic [CAP_W-1:0] MIN_SLOTS   = 13'd16;
  localparam logic [CAP_W-1:0] SLOTS_RESET = 13'd4096;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [LVL_W-1:0] level;
  } slot_t;

  // Status of the probe engine seen by the top level
  typedef struct packed {
    logic             clearing;
    logic [CAP_W-1:0] entries;
  } back_stat_t;

endpackage

### design/klht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module klht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/klht_fifo.sv
// Two-entry queue between the hashing front end and the probe engine.
// No dependencies.
module klht_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

### design/klht_front.sv
// Front end: accepts keys, hashes them and reduces modulo the slot count.
// Depends on klht_pkg.
module klht_front #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clearing,
  input  logic [klht_pkg::CAP_W-1:0] cap,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [klht_pkg::KEY_W-1:0] in_key,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [klht_pkg::KEY_W-1:0] push_key,
  output logic [AW-1:0]              push_home
);
  import klht_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] prod_r, prod_nxt;
  logic [CAP_W-1:0] rem_r, rem_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [KEY_W-1:0] prod_lo;
  logic [CAP_W:0]   r;
  logic [KEY_W-1:0] p;

  assign in_stall   = (state_r != F_IDLE) || clearing;
  assign push_valid = (state_r == F_PUSH);
  assign push_key   = key_r;
  assign push_home  = AW'(rem_r);
  // Only the low 32 bits of the product form the hash
  assign prod_lo    = key_r * HASH_MULT;

  // Four restoring remainder steps per cycle
  always_comb begin
    r = {1'b0, rem_r};
    p = prod_r;
    for (int i = 0; i < 4; i++) begin
      r = {r[CAP_W-1:0], p[KEY_W-1]};
      p = {p[KEY_W-2:0], 1'b0};
      if (r >= {1'b0, cap}) begin
        r = r - {1'b0, cap};
      end
    end
  end

  // Sequence accept, multiply, reduce, hand over
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid && !in_stall) begin
          key_nxt   = in_key;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        prod_nxt  = prod_lo;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = F_DIV;
      end
      F_DIV: begin
        prod_nxt = p;
        rem_nxt  = r[CAP_W-1:0];
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

endmodule

### design/klht_back.sv
// Back end: clears and probes the slot memory, inserts new keys, holds the result.
// Depends on klht_pkg and klht_ram.
module klht_back #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AW          = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [klht_pkg::CAP_W-1:0] cap,
  input  logic                       clear_req,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic [klht_pkg::KEY_W-1:0] q_key,
  input  logic [AW-1:0]              q_home,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [klht_pkg::LVL_W-1:0] out_level,
  output logic                       out_table_full,
  output klht_pkg::back_stat_t       stat
);
  import klht_pkg::*;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_READ  = 3'd2;
  localparam logic [2:0] B_CHECK = 3'd3;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CAP_W-1:0] probes_r, probes_nxt;
  logic [CAP_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0] out_level_r, out_level_nxt;
  logic             out_full_r, out_full_nxt;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  slot_t            wr_slot, rd_slot;
  logic [$bits(slot_t)-1:0] rd_word;
  logic             hit, refuse, wrap, exhausted;
  logic [CAP_W-1:0] count_p1;

  klht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_addr (idx_r),
    .rd_data (rd_word)
  );

  assign rd_slot   = slot_t'(rd_word);
  assign hit       = rd_slot.valid && (rd_slot.key == key_r);
  assign count_p1  = count_r + CAP_W'(1);
  assign refuse    = (count_r >= (cap - CAP_W'(1)));
  assign wrap      = ((CAP_W + 1)'(idx_r) + (CAP_W + 1)'(1)) >= {1'b0, cap};
  assign exhausted = ({1'b0, probes_r} + (CAP_W + 1)'(1)) >= {1'b0, cap};

  assign q_ready        = (state_r == B_IDLE) && !out_valid_r && !clear_req;
  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_table_full = out_full_r;
  assign stat.clearing  = (state_r == B_CLEAR);
  assign stat.entries   = count_r;

  // Memory write: zero sweep, or insert of a new key
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_slot = '0;
    if (state_r == B_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
    end else if (state_r == B_CHECK && !rd_slot.valid && !refuse) begin
      wr_en         = 1'b1;
      wr_slot.valid = 1'b1;
      wr_slot.key   = key_r;
      wr_slot.level = count_p1[LVL_W-1:0];
    end
  end

  // Probe sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    key_nxt       = key_r;
    probes_nxt    = probes_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_full_nxt  = out_full_r;
    unique case (state_r)
      B_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid && q_ready) begin
          idx_nxt    = q_home;
          key_nxt    = q_key;
          probes_nxt = '0;
          state_nxt  = B_READ;
        end
      end
      B_READ: begin
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (!rd_slot.valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
          if (refuse) begin
            out_level_nxt = '0;
            out_full_nxt  = 1'b1;
          end else begin
            count_nxt     = count_p1;
            out_level_nxt = count_p1[LVL_W-1:0];
            out_full_nxt  = 1'b0;
          end
        end else if (hit) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = rd_slot.level;
          out_full_nxt  = 1'b0;
          state_nxt     = B_IDLE;
        end else if (exhausted) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = '0;
          out_full_nxt  = 1'b1;
          state_nxt     = B_IDLE;
        end else begin
          idx_nxt    = wrap ? '0 : idx_r + AW'(1);
          probes_nxt = probes_r + CAP_W'(1);
          state_nxt  = B_READ;
        end
      end
      default: state_nxt = B_CLEAR;
    endcase
    // Restart the sweep on a size write
    if (clear_req) begin
      state_nxt = B_CLEAR;
      clr_nxt   = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    probes_r    <= probes_nxt;
    out_level_r <= out_level_nxt;
    out_full_r  <= out_full_nxt;
  end

endmodule

### design/key_to_level_hash_table.sv
// Top level of the key-to-level hash table: size register, front end,
// queue and probe engine. Depends on klht_pkg, klht_front, klht_fifo, klht_back.
//
//   channel | ports                                 | handshake
//   input   | in_valid, in_stall, in_key            | valid / stall
//   result  | out_valid, out_stall, out_level,      | valid / stall
//           | out_table_full                        |
//   config  | cfg_valid, cfg_ready, cfg_slots_in_use| valid / ready
//
// The front end handles one key at a time: accept, one 32x32 multiply, a
// 4-bit-per-cycle remainder unit, hand-over to the queue.
// The probe engine does one memory read per probe, in a read and a check state.
// After reset and after every size write a sweep over all TABLE_DEPTH slots
// clears the slot memory; no key is accepted during it.
// Results wait in an output register while the front end hashes the next key.
module key_to_level_hash_table #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [klht_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [klht_pkg::LVL_W-1:0] out_level,
  output logic                       out_table_full,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [klht_pkg::CAP_W-1:0] cfg_slots_in_use
);
  import klht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [CAP_W-1:0] slots_r, slots_nxt;
  logic [CAP_W-1:0] cap;
  logic             cfg_fire;
  logic             q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  logic [KEY_W-1:0] f_key, q_key;
  logic [AW-1:0]    f_home, q_home;
  back_stat_t       stat;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign slots_nxt = cfg_fire ? cfg_slots_in_use : slots_r;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
    end else begin
      slots_r <= slots_nxt;
    end
  end

  // Saturate the slot count to the supported range
  always_comb begin
    cap = slots_r;
    if (slots_r < MIN_SLOTS) begin
      cap = MIN_SLOTS;
    end else if (32'(slots_r) > 32'(TABLE_DEPTH)) begin
      cap = CAP_W'(TABLE_DEPTH);
    end
  end

  klht_front #(
    .AW (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (stat.clearing),
    .cap        (cap),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_key     (in_key),
    .push_valid (q_wr_valid),
    .push_ready (q_wr_ready),
    .push_key   (f_key),
    .push_home  (f_home)
  );

  klht_fifo #(
    .WIDTH (KEY_W + AW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  ({f_key, f_home}),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  ({q_key, q_home})
  );

  klht_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap            (cap),
    .clear_req      (cfg_fire),
    .q_valid        (q_rd_valid),
    .q_ready        (q_rd_ready),
    .q_key          (q_key),
    .q_home         (q_home),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_table_full (out_table_full),
    .stat           (stat)
  );

  // A size write starts the clearing sweep
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> stat.clearing)
    else $error("size write did not start clearing");

  // Entry count never reaches the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.entries < cap)
    else $error("entry count at or above slot count");

  // No key is taken while the memory is being cleared
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> in_stall)
    else $error("key accepted during clearing");

  // No new result appears during the sweep
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing && !out_valid |=> !out_valid)
    else $error("result produced during clearing");

endmodule
